@@ hw/rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants, codes and types of the sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned OccBits    = $clog2(Capacity + 1);
  localparam int unsigned StatusBits = 2;

  typedef logic signed [KeyBits-1:0] key_t;
  typedef logic [OccBits-1:0]        occ_t;

  typedef enum logic {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_INSERT  = 2'd1,
    CELL_SHIFT   = 2'd2
  } cell_op_e;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    cell_op_e op;
    key_t     ins_key;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/smpq_in_if.sv @@
// ----------------------------------------------------------------------------
// smpq_in_if
// Request channel: insert a key or extract the minimum.
// ----------------------------------------------------------------------------
interface smpq_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  smpq_pkg::key_t  key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

@@ hw/rtl/smpq_out_if.sv @@
// ----------------------------------------------------------------------------
// smpq_out_if
// Response channel: removed key, status and occupancy.
// ----------------------------------------------------------------------------
interface smpq_out_if;
  logic                                 valid;
  logic                                 ready;
  smpq_pkg::key_t                       min_key;
  logic [smpq_pkg::StatusBits-1:0]      status;
  smpq_pkg::occ_t                       occupancy;

  modport source (output valid, output min_key, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input min_key, input status, input occupancy,
                  output ready);
endinterface

@@ hw/rtl/sorted_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Min-priority queue kept as a chain of key cells sorted ascending.
// ----------------------------------------------------------------------------
// The response beat is registered and appears in the cycle after the request.
// Throughput: one request per cycle unless the response is stalled; each cell
// compares and shifts in parallel within the cycle; chain length sets no rate.
// Reset clears the occupancy count, the response valid flag and the status;
// the key cells are not reset and are read only below the occupancy count.
module sorted_min_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  smpq_in_if.sink    in_i,
  smpq_out_if.source out_o
);

  localparam int unsigned Cap = smpq_pkg::Capacity;

  smpq_pkg::occ_t       count_q, count_d;
  logic                 out_valid_q;
  smpq_pkg::key_t       min_key_q, min_key_d;
  smpq_pkg::status_e    status_q, status_d;
  smpq_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 full, empty;

  logic           less [Cap];
  smpq_pkg::key_t keys [Cap];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == smpq_pkg::OccBits'(Cap));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.op      = smpq_pkg::CELL_HOLD;
    ctrl.ins_key = in_i.key;
    count_d      = count_q;
    min_key_d    = '0;
    status_d     = smpq_pkg::STATUS_OK;
    if (in_i.kind == smpq_pkg::KIND_INSERT) begin
      if (full) begin
        status_d = smpq_pkg::STATUS_FULL;
      end else begin
        ctrl.op = accept ? smpq_pkg::CELL_INSERT : smpq_pkg::CELL_HOLD;
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = smpq_pkg::STATUS_EMPTY;
      end else begin
        ctrl.op   = accept ? smpq_pkg::CELL_SHIFT : smpq_pkg::CELL_HOLD;
        min_key_d = keys[0];
        count_d   = count_q - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic           left_less;
    smpq_pkg::key_t left_key;
    smpq_pkg::key_t right_key;

    if (i == 0) begin : g_head
      assign left_less = 1'b1;
      assign left_key  = in_i.key;
    end else begin : g_body
      assign left_less = less[i-1];
      assign left_key  = keys[i-1];
    end

    if (i == Cap - 1) begin : g_tail
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > smpq_pkg::OccBits'(i)),
      .left_less_i (left_less),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .less_o      (less[i]),
      .key_o       (keys[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= smpq_pkg::STATUS_OK;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_key_q <= min_key_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.min_key   = min_key_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = count_q;

endmodule

@@ hw/rtl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds a key, compares it against the key
// being inserted and takes a neighbor's key when the chain shifts.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                 clk_i,
  input  smpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  logic                 left_less_i,
  input  smpq_pkg::key_t       left_key_i,
  input  smpq_pkg::key_t       right_key_i,
  output logic                 less_o,
  output smpq_pkg::key_t       key_o
);

  smpq_pkg::key_t key_q, key_d;

  // Along a sorted chain the less flags form a thermometer code, so the
  // first cell that is not less than the new key is where it lands.
  assign less_o = valid_i && (key_q < ctrl_i.ins_key);
  assign key_o  = key_q;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.op)
      smpq_pkg::CELL_INSERT: begin
        if (!less_o) begin
          key_d = left_less_i ? ctrl_i.ins_key : left_key_i;
        end
      end
      smpq_pkg::CELL_SHIFT: key_d = right_key_i;
      default:              key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
